### sv/rtf_pkg.sv
// ----------------------------------------------------------------------------
// rtf_pkg
// Shared widths, region codes and constants for the radiation term pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rtf_pkg;

  localparam int unsigned WN_W   = 23;
  localparam int unsigned TS_W   = 18;
  localparam int unsigned Q32_W  = 32;
  localparam int unsigned R_W    = 36;
  localparam int unsigned NUM_W  = 56;
  localparam int unsigned DEN_W  = 33;
  localparam int unsigned SQ_CNT = 8;

  typedef enum logic [1:0] {
    REG_PASS   = 2'd0,
    REG_TAYLOR = 2'd1,
    REG_MID    = 2'd2
  } region_e;

  typedef struct packed {
    region_e           region;
    logic [TS_W-1:0]   ts;
    logic [WN_W-1:0]   wn;
  } item_t;

  typedef struct packed {
    region_e           region;
    logic [WN_W-1:0]   wn;
  } tail_t;

endpackage

`default_nettype wire

### sv/rtf_div.sv
// ----------------------------------------------------------------------------
// rtf_div
// Pipelined restoring divider, one quotient bit per stage.
// Requires n < d * 2**QW; side data travels with each word.
// ----------------------------------------------------------------------------
`default_nettype none

module rtf_div #(
  parameter int unsigned NW = 56,
  parameter int unsigned DW = 33,
  parameter int unsigned QW = 23,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          vld_i,
  input  wire logic [NW-1:0] n_i,
  input  wire logic [DW-1:0] d_i,
  input  wire logic [SW-1:0] side_i,
  output logic               vld_o,
  output logic [QW-1:0]      q_o,
  output logic [SW-1:0]      side_o
);

  logic          vld_a  [QW+1];
  logic [DW-1:0] rem_a  [QW+1];
  logic [QW-1:0] sh_a   [QW+1];
  logic [QW-1:0] quo_a  [QW+1];
  logic [DW-1:0] d_a    [QW+1];
  logic [SW-1:0] side_a [QW+1];

  assign vld_a[0]  = vld_i;
  assign rem_a[0]  = DW'(n_i[NW-1:QW]);
  assign sh_a[0]   = n_i[QW-1:0];
  assign quo_a[0]  = '0;
  assign d_a[0]    = d_i;
  assign side_a[0] = side_i;

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic          vld_q;
    logic [DW-1:0] rem_q, rem_d;
    logic [QW-1:0] sh_q, quo_q, quo_d;
    logic [DW-1:0] d_q;
    logic [SW-1:0] side_q;
    logic [DW:0]   trial;

    always_comb begin
      trial = {rem_a[g], sh_a[g][QW-1]};
      if (trial >= {1'b0, d_a[g]}) begin
        rem_d = DW'(trial - {1'b0, d_a[g]});
        quo_d = {quo_a[g][QW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_a[g][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_a[g];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q  <= rem_d;
      sh_q   <= {sh_a[g][QW-2:0], 1'b0};
      quo_q  <= quo_d;
      d_q    <= d_a[g];
      side_q <= side_a[g];
    end

    assign vld_a[g+1]  = vld_q;
    assign rem_a[g+1]  = rem_q;
    assign sh_a[g+1]   = sh_q;
    assign quo_a[g+1]  = quo_q;
    assign d_a[g+1]    = d_q;
    assign side_a[g+1] = side_q;
  end

  assign vld_o  = vld_a[QW];
  assign q_o    = quo_a[QW];
  assign side_o = side_a[QW];

  // remainder stays below the divisor at the last stage
  property p_rem_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      vld_a[QW] && ($past(vld_a[0], QW) == 1'b1) && (d_a[QW] != '0)
      && ($past(rem_a[0], QW) < $past(d_a[0], QW)) |-> rem_a[QW] < d_a[QW];
  endproperty
  a_rem_bound: assert property (p_rem_bound) else $error("divider remainder out of range");

endmodule

`default_nettype wire

### sv/rtf_exp.sv
// ----------------------------------------------------------------------------
// rtf_exp
// Pipelined e^-r in Q32: seven-term series on r/256, then eight squarings.
// Three stages per series term, one for the combine, one per squaring.
// ----------------------------------------------------------------------------
`default_nettype none

module rtf_exp
  import rtf_pkg::*;
#(
  parameter int unsigned SW = 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             vld_i,
  input  wire logic [R_W-1:0]   r_i,
  input  wire logic [SW-1:0]    side_i,
  output logic                  vld_o,
  output logic [Q32_W-1:0]      e_o,
  output logic [SW-1:0]         side_o
);

  localparam int unsigned Y_W    = R_W - SQ_CNT;
  localparam int unsigned X_W    = 2 * Y_W - Q32_W;
  localparam int unsigned ACC_W  = Q32_W + 2;
  localparam int unsigned SH     = X_W + 2;
  localparam int unsigned TERMS  = 5;

  logic             vld_a  [TERMS+1];
  logic [Y_W-1:0]   y_a    [TERMS+1];
  logic [Y_W-1:0]   t_a    [TERMS+1];
  logic [ACC_W-1:0] pos_a  [TERMS+1];
  logic [ACC_W-1:0] neg_a  [TERMS+1];
  logic [SW-1:0]    side_a [TERMS+1];

  assign vld_a[0]  = vld_i;
  assign y_a[0]    = r_i[R_W-1:SQ_CNT];
  assign t_a[0]    = r_i[R_W-1:SQ_CNT];
  assign pos_a[0]  = ACC_W'(64'd1 << Q32_W);
  assign neg_a[0]  = ACC_W'(r_i[R_W-1:SQ_CNT]);
  assign side_a[0] = side_i;

  for (genvar j = 1; j <= TERMS; j++) begin : g_term
    localparam int unsigned K = j + 1;
    localparam logic [SH:0] M = (SH+1)'((64'd1 << SH) / K);

    logic             a_vld_q, b_vld_q, c_vld_q;
    logic [X_W-1:0]   a_x_q, b_x_q;
    logic [X_W-1:0]   b_q0_q;
    logic [Y_W-1:0]   a_y_q, b_y_q, c_y_q;
    logic [ACC_W-1:0] a_pos_q, a_neg_q, b_pos_q, b_neg_q, c_pos_q, c_neg_q;
    logic [SW-1:0]    a_side_q, b_side_q, c_side_q;
    logic [Y_W-1:0]   c_t_q;
    logic [2*Y_W-1:0] prod_a;
    logic [X_W+SH:0]  prod_b;
    logic [X_W+2:0]   rm;
    logic [X_W-1:0]   tk;

    assign prod_a = t_a[j-1] * y_a[j-1];
    assign prod_b = a_x_q * M;
    assign rm     = (X_W+3)'(b_x_q) - (X_W+3)'(b_q0_q * (X_W+3)'(K));
    assign tk     = (rm >= (X_W+3)'(K)) ? X_W'(b_q0_q + 1'b1) : b_q0_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_vld_q <= 1'b0;
        b_vld_q <= 1'b0;
        c_vld_q <= 1'b0;
      end else begin
        a_vld_q <= vld_a[j-1];
        b_vld_q <= a_vld_q;
        c_vld_q <= b_vld_q;
      end
    end

    always_ff @(posedge clk_i) begin
      a_x_q    <= prod_a[2*Y_W-1:Q32_W];
      a_y_q    <= y_a[j-1];
      a_pos_q  <= pos_a[j-1];
      a_neg_q  <= neg_a[j-1];
      a_side_q <= side_a[j-1];
      b_x_q    <= a_x_q;
      b_q0_q   <= prod_b[X_W+SH-1:SH];
      b_y_q    <= a_y_q;
      b_pos_q  <= a_pos_q;
      b_neg_q  <= a_neg_q;
      b_side_q <= a_side_q;
      c_t_q    <= Y_W'(tk);
      c_y_q    <= b_y_q;
      c_side_q <= b_side_q;
      if ((K % 2) == 0) begin
        c_pos_q <= b_pos_q + ACC_W'(tk);
        c_neg_q <= b_neg_q;
      end else begin
        c_pos_q <= b_pos_q;
        c_neg_q <= b_neg_q + ACC_W'(tk);
      end
    end

    assign vld_a[j]  = c_vld_q;
    assign y_a[j]    = c_y_q;
    assign t_a[j]    = c_t_q;
    assign pos_a[j]  = c_pos_q;
    assign neg_a[j]  = c_neg_q;
    assign side_a[j] = c_side_q;
  end

  logic             sq_vld_a  [SQ_CNT+1];
  logic [Q32_W-1:0] sq_e_a    [SQ_CNT+1];
  logic [SW-1:0]    sq_side_a [SQ_CNT+1];
  logic             sum_vld_q;
  logic [Q32_W-1:0] sum_e_q, sum_e_d;
  logic [SW-1:0]    sum_side_q;
  logic [ACC_W-1:0] diff;

  always_comb begin
    diff = (pos_a[TERMS] > neg_a[TERMS]) ? (pos_a[TERMS] - neg_a[TERMS]) : '0;
    if (diff[ACC_W-1:Q32_W] != '0) begin
      sum_e_d = '1;
    end else begin
      sum_e_d = diff[Q32_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
    end else begin
      sum_vld_q <= vld_a[TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_e_q    <= sum_e_d;
    sum_side_q <= side_a[TERMS];
  end

  assign sq_vld_a[0]  = sum_vld_q;
  assign sq_e_a[0]    = sum_e_q;
  assign sq_side_a[0] = sum_side_q;

  for (genvar s = 0; s < SQ_CNT; s++) begin : g_sq
    logic               vld_q;
    logic [Q32_W-1:0]   e_q;
    logic [SW-1:0]      side_q;
    logic [2*Q32_W-1:0] sq;

    assign sq = sq_e_a[s] * sq_e_a[s];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= sq_vld_a[s];
      end
    end

    always_ff @(posedge clk_i) begin
      e_q    <= sq[2*Q32_W-1:Q32_W];
      side_q <= sq_side_a[s];
    end

    assign sq_vld_a[s+1]  = vld_q;
    assign sq_e_a[s+1]    = e_q;
    assign sq_side_a[s+1] = side_q;
  end

  assign vld_o  = sq_vld_a[SQ_CNT];
  assign e_o    = sq_e_a[SQ_CNT];
  assign side_o = sq_side_a[SQ_CNT];

  // squaring never grows the value
  a_sq_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld_a[1] |-> sq_e_a[1] <= $past(sq_e_a[0]))
    else $error("squaring grew the value");

endmodule

`default_nettype wire

### sv/radiation_term_function_top.sv
// ----------------------------------------------------------------------------
// radiation_term_function_top
// Radiation field term: wavenumber * tanh(r/2), Taylor form for small r,
// wavenumber itself for large r or zero thermal scale, r = wavenumber / thermal scale.
// ----------------------------------------------------------------------------
// Path from start to valid_o: entry register, ratio divider, series and squarings,
//   product register, final divider.
// Throughput: one word per cycle; every stage is a register, busy stays low.
// The receiver cannot stall; each result shows for one cycle with valid_o.
// Reset clears all valid bits at once; data registers are not reset.
`default_nettype none

module radiation_term_function_top
  import rtf_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [WN_W-1:0] wavenumber_i,
  input  wire logic [TS_W-1:0] thermal_scale_i,
  output logic                 valid_o,
  output logic [WN_W-1:0]      radiation_term_o
);

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned TAIL_W = $bits(tail_t);

  assign busy = 1'b0;

  region_e    region_d;
  logic       in_vld_q;
  item_t      in_q;

  always_comb begin
    if (thermal_scale_i == '0) begin
      region_d = REG_PASS;
    end else if ((30'(wavenumber_i) * 30'd100) <= 30'(thermal_scale_i)) begin
      region_d = REG_TAYLOR;
    end else if (23'(wavenumber_i) <= (23'(thermal_scale_i) * 23'd10)) begin
      region_d = REG_MID;
    end else begin
      region_d = REG_PASS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q.region <= region_d;
    in_q.ts     <= thermal_scale_i;
    in_q.wn     <= wavenumber_i;
  end

  logic             d1_vld;
  logic [R_W-1:0]   d1_q;
  logic [ITEM_W-1:0] d1_side;

  rtf_div #(
    .NW (WN_W + Q32_W),
    .DW (TS_W + 1),
    .QW (R_W),
    .SW (ITEM_W)
  ) u_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (in_vld_q),
    .n_i    ({in_q.wn, {Q32_W{1'b0}}}),
    .d_i    ({1'b0, in_q.ts}),
    .side_i (in_q),
    .vld_o  (d1_vld),
    .q_o    (d1_q),
    .side_o (d1_side)
  );

  logic              ex_vld;
  logic [Q32_W-1:0]  ex_e;
  logic [ITEM_W-1:0] ex_side;
  item_t             ex_item;

  rtf_exp #(
    .SW (ITEM_W)
  ) u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (d1_vld),
    .r_i    (d1_q),
    .side_i (d1_side),
    .vld_o  (ex_vld),
    .e_o    (ex_e),
    .side_o (ex_side)
  );

  assign ex_item = item_t'(ex_side);

  logic [DEN_W-1:0] mul_op, den_d;
  logic             pr_vld_q;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  tail_t            pr_tail_q;
  logic [NUM_W-1:0] num_d;

  always_comb begin
    unique case (ex_item.region)
      REG_TAYLOR: begin
        mul_op = DEN_W'(ex_item.wn);
        den_d  = DEN_W'({ex_item.ts, 1'b0});
      end
      REG_MID: begin
        mul_op = DEN_W'(34'(64'd1 << Q32_W) - 34'(ex_e));
        den_d  = {1'b1, ex_e};
      end
      default: begin
        mul_op = DEN_W'(1);
        den_d  = DEN_W'(1);
      end
    endcase
    num_d = NUM_W'(ex_item.wn) * NUM_W'(mul_op);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
    end else begin
      pr_vld_q <= ex_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q            <= num_d;
    den_q            <= den_d;
    pr_tail_q.region <= ex_item.region;
    pr_tail_q.wn     <= ex_item.wn;
  end

  logic [TAIL_W-1:0] out_side;
  tail_t             out_tail;

  rtf_div #(
    .NW (NUM_W),
    .DW (DEN_W),
    .QW (WN_W),
    .SW (TAIL_W)
  ) u_final (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (pr_vld_q),
    .n_i    (num_q),
    .d_i    (den_q),
    .side_i (pr_tail_q),
    .vld_o  (valid_o),
    .q_o    (radiation_term_o),
    .side_o (out_side)
  );

  assign out_tail = tail_t'(out_side);

  a_not_above_wn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> radiation_term_o <= out_tail.wn)
    else $error("result above wavenumber");

  a_pass_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_tail.region == REG_PASS |-> radiation_term_o == out_tail.wn)
    else $error("pass-through word altered");

  a_taylor_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_tail.region == REG_TAYLOR
      |-> (31'(radiation_term_o) * 31'd200) <= 31'(out_tail.wn))
    else $error("small-ratio result too large");

endmodule

`default_nettype wire

### tb/sv/radiation_term_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radiation_term_checker
// Watches accepted words on the command and result sides, computes the
// expected radiation term for each command and compares results in order.
// ----------------------------------------------------------------------------
`default_nettype none

module radiation_term_checker
  import rtf_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire logic            busy,
  input  wire logic [WN_W-1:0] wavenumber_i,
  input  wire logic [TS_W-1:0] thermal_scale_i,
  input  wire logic            valid_o,
  input  wire logic [WN_W-1:0] radiation_term_o,
  output int                   fail_count,
  output int                   pending_terms
);

  logic [WN_W-1:0] term_queue[$];

  function automatic logic [63:0] exp_neg_q32(input logic [63:0] ratio);
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    y = ratio >> SQ_CNT;
    t = y;
    pos = 64'd1 << 32;
    neg = t;
    for (int k = 2; k <= 6; k++) begin
      t = ((t * y) >> 32) / k;
      if (k % 2 == 0) pos += t;
      else neg += t;
    end
    e = (pos > neg) ? pos - neg : 64'd0;
    if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
    for (int i = 0; i < SQ_CNT; i++) e = (e * e) >> 32;
    return e;
  endfunction

  function automatic logic [WN_W-1:0] radiation_term(input logic [WN_W-1:0] wn_in,
                                                     input logic [TS_W-1:0] ts_in);
    logic [63:0] wn;
    logic [63:0] ts;
    logic [63:0] e;
    logic [63:0] res;
    wn = 64'(wn_in);
    ts = 64'(ts_in);
    if (ts == 0) res = wn;
    else if (wn * 100 <= ts) res = (wn * wn) / (2 * ts);
    else if (wn <= ts * 10) begin
      e = exp_neg_q32((wn << 32) / ts);
      res = (wn * ((64'd1 << 32) - e)) / ((64'd1 << 32) + e);
    end else res = wn;
    return res[WN_W-1:0];
  endfunction

  task automatic report(input string what, input logic [WN_W-1:0] got,
                        input logic [WN_W-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) term_queue.push_back(radiation_term(wavenumber_i, thermal_scale_i));
      if (valid_o) begin
        if (term_queue.size() == 0) report("unexpected word", radiation_term_o, '0);
        else begin
          if (radiation_term_o !== term_queue[0])
            report("radiation_term", radiation_term_o, term_queue[0]);
          void'(term_queue.pop_front());
        end
      end
    end
    pending_terms = term_queue.size();
  end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random wavenumber / thermal scale words into the
// radiation term pipeline with random gaps; the checker scores the results.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import rtf_pkg::*;
();

  localparam int WATCHDOG = 20000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [WN_W-1:0] wavenumber_i = '0;
  logic [TS_W-1:0] thermal_scale_i = '1;
  logic            valid_o;
  logic [WN_W-1:0] radiation_term_o;
  int              fail_count;
  int              pending_terms;
  int              idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  radiation_term_function_top DUT (.*);
  radiation_term_checker u_checker (.*);

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_word(input logic [WN_W-1:0] wn, input logic [TS_W-1:0] ts);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    wavenumber_i <= wn;
    thermal_scale_i <= ts;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    logic [TS_W-1:0] ts;
    logic [WN_W-1:0] wn;
    int pick;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, zero scale, zero wavenumber, region boundaries
    send_word('0, '0);
    send_word(23'h7FFFFF, '0);
    send_word('0, 18'h3FFFF);
    send_word(23'h7FFFFF, 18'h3FFFF);
    send_word(23'h7FFFFF, 18'd1);
    send_word(23'd1, 18'd1);
    send_word(23'd1, 18'd100);
    send_word(23'd1, 18'd101);
    send_word(23'd1, 18'd99);
    send_word(23'd2621, 18'h3FFFF);
    send_word(23'd2622, 18'h3FFFF);
    send_word(23'd1000, 18'd100);
    send_word(23'd1001, 18'd100);
    send_word(23'd999, 18'd100);
    send_word(23'd6400000, 18'd160000);
    send_word(23'd6400000, 18'd262143);
    send_word(23'd500, 18'd1000);
    send_word(23'h555555, 18'h2AAAA);
    send_word(23'h2AAAAA, 18'h15555);
    for (int n = 0; n < 1200; n++) begin
      pick = $urandom_range(0, 9);
      ts = TS_W'($urandom_range(0, 18'h3FFFF));
      if (pick < 6) begin
        // middle region mostly
        if (ts == 0) ts = 1;
        wn = WN_W'($urandom_range(ts / 100, 10 * ts));
      end else if (pick < 8) wn = WN_W'($urandom_range(0, ts / 100 + 1));
      else wn = WN_W'($urandom_range(0, 23'h7FFFFF));
      send_word(wn, ts);
    end
    start <= 1'b0;
    while (pending_terms != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

### radiation_term_function_top.f
sv/rtf_pkg.sv
sv/rtf_div.sv
sv/rtf_exp.sv
sv/radiation_term_function_top.sv
tb/sv/radiation_term_checker.sv
tb/sv/testbench.sv
